// ===== rtl/core/bfeg_pkg.sv =====
// package: shared types and constants of the beacon fade envelope generator
`timescale 1ns / 1ps
`default_nettype none

package bfeg_pkg;

    // envelope phases
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_UP   = 3'd1,
        PH_TOP  = 3'd2,
        PH_DOWN = 3'd3,
        PH_ZERO = 3'd4
    } phase_t;

    // input action codes
    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_HOLD    = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    localparam int unsigned TICKS_PER_SEC_DEF = 62;

    localparam logic [7:0]  TARGET_RESET  = 8'd60;
    localparam logic [7:0]  PERIOD_RESET  = 8'd2;
    localparam logic [7:0]  PERIOD_MAX    = 8'd255;

    localparam logic [16:0] UP_STEP_MS    = 17'd2;
    localparam logic [16:0] TOP_MS_PER_S  = 17'd250;
    localparam logic [16:0] ZERO_MS_PER_S = 17'd480;
    localparam logic [7:0]  DOWN_KNEE     = 8'd30;
    localparam logic [16:0] DOWN_FAST_MS  = 17'd5;
    localparam logic [16:0] DOWN_SLOW_MS  = 17'd8;
    localparam logic [8:0]  UP_INCR       = 9'd2;

endpackage

`default_nettype wire

// ===== rtl/core/beacon_fade_envelope_generator_top.sv =====
// top level: beacon brightness envelope generator with input and result registers
`timescale 1ns / 1ps
`default_nettype none

// The block steps a repeating beacon brightness envelope, one beat per millisecond
// tick: an even-level ramp up below target_level (2 ms per level), a hold at the
// target for period*250 ms, a ramp down to 1 (5 ms per level above 30, 8 ms at or below),
// and a dark hold for period*480 ms. A new envelope starts only while button_down is
// low. Hold beats report blink on whole seconds of hold_ticks, and release beats set
// period_seconds to 1 + hold_ticks / TICKS_PER_SEC, saturated at 255. Each input beat
// gives exactly one result beat. Throughput is one beat per clock while out_stall is
// low: an accepted beat is held in the input register, and the phase counter and the
// single 16 x 33 bit reciprocal multiply for the seconds math run between that
// register and the result register, from which the result is offered. in_stall rises
// only when the result register is full and stalled. target_level is written through
// the cfg channel, which is always ready; write it only while no beat is in flight.
module beacon_fade_envelope_generator_top #(
    parameter int unsigned TICKS_PER_SEC = bfeg_pkg::TICKS_PER_SEC_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // config write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_target_level,

    // input beats
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [15:0] hold_ticks,
    input  wire logic        button_down,

    // result beats
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       level,
    output logic             blink,
    output logic [7:0]       period_seconds
);

    // reciprocal of the tick rate, rounded up, scaled by 2^32; exact for 16-bit counts
    localparam logic [63:0] RECIP_W =
        ((64'd1 << 32) + 64'(TICKS_PER_SEC) - 64'd1) / 64'(TICKS_PER_SEC);
    localparam logic [32:0] RECIP = RECIP_W[32:0];

    // config register
    logic [7:0] target_reg;

    // input stage
    logic        v1_reg;
    logic [1:0]  act_in_reg;
    logic [15:0] ticks_in_reg;
    logic        btn_in_reg;

    // envelope state
    bfeg_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  lvl_reg, lvl_next;
    logic [16:0] ms_reg, ms_next;
    logic [7:0]  period_reg, period_next;

    // result stage
    logic        v2_reg;
    logic [7:0]  out_level_reg;
    logic        out_blink_reg;
    logic [7:0]  out_period_reg;

    logic        move;
    logic        accept;
    logic        blink_next;

    // seconds math
    logic [48:0] prod;
    logic [16:0] quot;
    logic [31:0] frac;
    logic        whole_sec;

    // envelope step helpers
    logic [16:0] ms_dec;
    logic [8:0]  up_next;
    logic        start_req;
    logic        top_req;
    logic        down_req;
    logic [7:0]  down_lv;

    // handshake: stage 1 drains whenever the result register is free or being taken
    assign move      = v1_reg && (!v2_reg || !out_stall);
    assign in_stall  = v1_reg && !move;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign out_valid      = v2_reg;
    assign level          = out_level_reg;
    assign blink          = out_blink_reg;
    assign period_seconds = out_period_reg;

    // quotient in the high bits, divisibility from the fraction in the low bits
    assign prod      = 49'(ticks_in_reg) * 49'(RECIP);
    assign quot      = prod[48:32];
    assign frac      = prod[31:0];
    assign whole_sec = ({1'b0, frac} < RECIP);

    assign ms_dec  = (ms_reg != 17'd0) ? (ms_reg - 17'd1) : 17'd0;
    assign up_next = {1'b0, lvl_reg} + bfeg_pkg::UP_INCR;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= bfeg_pkg::TARGET_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            target_reg <= cfg_target_level;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (accept)
        begin
            v1_reg <= 1'b1;
        end
        else if (move)
        begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_in_reg   <= action;
            ticks_in_reg <= hold_ticks;
            btn_in_reg   <= button_down;
        end
    end

    // envelope state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= bfeg_pkg::PH_IDLE;
            lvl_reg    <= 8'd0;
            ms_reg     <= 17'd0;
            period_reg <= bfeg_pkg::PERIOD_RESET;
        end
        else
        begin
            phase_reg  <= phase_next;
            lvl_reg    <= lvl_next;
            ms_reg     <= ms_next;
            period_reg <= period_next;
        end
    end

    // next state of the envelope and the result fields
    always_comb
    begin
        phase_next  = phase_reg;
        lvl_next    = lvl_reg;
        ms_next     = ms_reg;
        period_next = period_reg;
        blink_next  = 1'b0;
        start_req   = 1'b0;
        top_req     = 1'b0;
        down_req    = 1'b0;
        down_lv     = lvl_reg;

        if (move)
        begin
            case (act_in_reg)
                bfeg_pkg::ACT_TICK:
                begin
                    if (phase_reg == bfeg_pkg::PH_IDLE)
                    begin
                        start_req = !btn_in_reg;
                    end
                    else if (ms_dec != 17'd0)
                    begin
                        ms_next = ms_dec;
                    end
                    else
                    begin
                        // step ends on this tick
                        unique case (phase_reg)
                            bfeg_pkg::PH_UP:
                            begin
                                if (up_next < {1'b0, target_reg})
                                begin
                                    lvl_next = up_next[7:0];
                                    ms_next  = bfeg_pkg::UP_STEP_MS;
                                end
                                else
                                begin
                                    top_req = 1'b1;
                                end
                            end
                            bfeg_pkg::PH_TOP:
                            begin
                                down_req = 1'b1;
                                down_lv  = target_reg;
                            end
                            bfeg_pkg::PH_DOWN:
                            begin
                                down_req = 1'b1;
                                down_lv  = lvl_reg - 8'd1;
                            end
                            default:
                            begin
                                // end of the dark hold
                                if (btn_in_reg)
                                begin
                                    phase_next = bfeg_pkg::PH_IDLE;
                                    lvl_next   = 8'd0;
                                    ms_next    = 17'd0;
                                end
                                else
                                begin
                                    start_req = 1'b1;
                                end
                            end
                        endcase
                    end
                end
                bfeg_pkg::ACT_HOLD:
                begin
                    blink_next = whole_sec;
                end
                bfeg_pkg::ACT_RELEASE:
                begin
                    period_next = (quot >= 17'(bfeg_pkg::PERIOD_MAX)) ?
                                  bfeg_pkg::PERIOD_MAX : (quot[7:0] + 8'd1);
                end
                default:
                begin
                end
            endcase
        end

        // new envelope; a zero target skips straight to the top hold
        if (start_req)
        begin
            if (target_reg != 8'd0)
            begin
                phase_next = bfeg_pkg::PH_UP;
                lvl_next   = 8'd0;
                ms_next    = bfeg_pkg::UP_STEP_MS;
            end
            else
            begin
                top_req = 1'b1;
            end
        end

        if (top_req)
        begin
            phase_next = bfeg_pkg::PH_TOP;
            lvl_next   = target_reg;
            ms_next    = 17'(period_reg) * bfeg_pkg::TOP_MS_PER_S;
        end

        if (down_req)
        begin
            if (down_lv == 8'd0)
            begin
                phase_next = bfeg_pkg::PH_ZERO;
                lvl_next   = 8'd0;
                ms_next    = 17'(period_reg) * bfeg_pkg::ZERO_MS_PER_S;
            end
            else
            begin
                phase_next = bfeg_pkg::PH_DOWN;
                lvl_next   = down_lv;
                ms_next    = (down_lv > bfeg_pkg::DOWN_KNEE) ?
                             bfeg_pkg::DOWN_FAST_MS : bfeg_pkg::DOWN_SLOW_MS;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (move)
        begin
            v2_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            v2_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_level_reg  <= lvl_next;
            out_blink_reg  <= blink_next;
            out_period_reg <= period_next;
        end
    end

    // every active step carries a nonzero duration
    a_busy_has_time: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != bfeg_pkg::PH_IDLE |-> ms_reg != 17'd0)
        else $error("active phase with zero remaining time");

    // idle sits dark with a cleared counter
    a_idle_dark: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == bfeg_pkg::PH_IDLE |-> (lvl_reg == 8'd0 && ms_reg == 17'd0))
        else $error("idle phase with nonzero level or counter");

    // ramp up stays on even levels
    a_up_even: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == bfeg_pkg::PH_UP |-> lvl_reg[0] == 1'b0)
        else $error("odd level during ramp up");

    // ramp down never shows zero and uses short steps only
    a_down_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == bfeg_pkg::PH_DOWN |-> (lvl_reg != 8'd0 &&
                                             ms_reg <= bfeg_pkg::DOWN_SLOW_MS))
        else $error("ramp down level or step length out of range");

    // state changes only while a beat moves into the result register
    a_state_on_move: assert property (@(posedge clk) disable iff (!rst_n)
        !move |=> ($stable(lvl_reg) && $stable(ms_reg) && $stable(period_reg)))
        else $error("envelope state changed without a beat");

endmodule

`default_nettype wire
